### sv/tba_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and reset values for the trade bar aggregator.
// No dependencies; imported by every module of the block.
package tba_pkg;

  localparam int TS_W  = 63;  // timestamps and dollar volume
  localparam int SYM_W = 16;
  localparam int CNT_W = 32;
  localparam int VOL_W = 48;
  localparam int LEN_W = 40;

  localparam logic [LEN_W-1:0] LEN_RESET = 40'd300000000000;

  // shared radix-2 divider: 63-bit dividend, 48-bit divisor
  localparam int DIV_N_W   = TS_W;
  localparam int DIV_D_W   = VOL_W;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(DIV_N_W - 1);

  localparam logic CMD_TRADE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [1:0] SIDE_BID = 2'd0;
  localparam logic [1:0] SIDE_ASK = 2'd1;

endpackage

### sv/tba_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tba_pkg for operand widths.
module tba_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tba_pkg::DIV_N_W-1:0]  dividend_i,
  input  logic [tba_pkg::DIV_D_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [tba_pkg::DIV_N_W-1:0]  quotient_o,
  output logic [tba_pkg::DIV_D_W-1:0]  remainder_o
);
  import tba_pkg::*;

  logic [DIV_N_W-1:0]   dvd_q;   // dividend shifts out, quotient shifts in
  logic [DIV_D_W-1:0]   dvs_q;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_D_W:0]     trial, diff;
  logic                 ge;

  always_comb begin
    trial = {rem_q, dvd_q[DIV_N_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[DIV_N_W-2:0], ge};
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

### sv/tba_mul.sv
`timescale 1ns / 1ps
// Serial shift-add multiplier, one multiplier bit per cycle, with the
// product saturated to the dollar volume width. Depends on tba_pkg.
module tba_mul #(
  parameter int PRICE_BITS = 32,
  parameter int SIZE_BITS  = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [PRICE_BITS-1:0]      mcand_i,
  input  logic [SIZE_BITS-1:0]       mplr_i,
  output logic [tba_pkg::TS_W-1:0]   prod_o
);
  import tba_pkg::*;

  localparam int PW = PRICE_BITS + SIZE_BITS;
  localparam int CW = $clog2(SIZE_BITS + 1);
  localparam logic [CW-1:0] LAST = CW'(SIZE_BITS - 1);

  logic [PRICE_BITS-1:0] mcand_q, hi_q;
  logic [SIZE_BITS-1:0]  lo_q;     // multiplier out, low product bits in
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic [PRICE_BITS:0]   psum;
  logic [PW-1:0]         prod;

  assign psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
  assign prod = {hi_q, lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
    end else if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplr_i;
      cnt_q   <= '0;
      busy_q  <= 1'b1;
    end else if (busy_q) begin
      hi_q  <= psum[PRICE_BITS:1];
      lo_q  <= {psum[0], lo_q[SIZE_BITS-1:1]};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) busy_q <= 1'b0;
    end
  end

  generate
    if (PW > TS_W) begin : g_sat
      assign prod_o = (|prod[PW-1:TS_W]) ? '1 : prod[TS_W-1:0];
    end else begin : g_nosat
      assign prod_o = TS_W'(prod);
    end
  endgenerate

endmodule

### sv/trade_bar_aggregator_core.sv
`timescale 1ns / 1ps
// Trade bar aggregator top level: bar state, sequencer, output register.
// A trade keeps in_ready_o low from acceptance until it is applied, through
// the radix-2 divider pass that finds the interval start; a trade that closes
// a bar adds the VWAP division on the same divider; a flush of an open bar runs
// only that division, a flush with no open bar none. A stalled output holds EMIT.
// Reset closes the bar, clears all sums and loads the 300 s interval.
module trade_bar_aggregator_core #(
  parameter int PRICE_BITS = 32,
  parameter int SIZE_BITS  = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tba_pkg::LEN_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [tba_pkg::TS_W-1:0]    timestamp_ns_i,
  input  logic [tba_pkg::SYM_W-1:0]   symbol_id_i,
  input  logic [PRICE_BITS-1:0]       price_i,
  input  logic [SIZE_BITS-1:0]        size_i,
  input  logic [1:0]                  side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tba_pkg::TS_W-1:0]    bar_start_ns_o,
  output logic [tba_pkg::SYM_W-1:0]   bar_symbol_o,
  output logic [tba_pkg::CNT_W-1:0]   trade_count_o,
  output logic [tba_pkg::VOL_W-1:0]   total_volume_o,
  output logic [tba_pkg::TS_W-1:0]    dollar_volume_o,
  output logic [PRICE_BITS-1:0]       vwap_o,
  output logic [PRICE_BITS-1:0]       first_price_o,
  output logic [PRICE_BITS-1:0]       last_price_o,
  output logic [tba_pkg::VOL_W-1:0]   bid_volume_o,
  output logic [tba_pkg::VOL_W-1:0]   ask_volume_o
);
  import tba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BUCKET, ST_CHECK, ST_VWAP, ST_EMIT, ST_APPLY
  } state_e;

  state_e state_q;
  logic [LEN_W-1:0] len_q;

  // latched transaction
  logic                  cmd_q;
  logic [TS_W-1:0]       ts_q;
  logic [SYM_W-1:0]      sym_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [SIZE_BITS-1:0]  size_q;
  logic [1:0]            side_q;
  logic [TS_W-1:0]       start_q;

  // open bar
  logic                  open_q;
  logic [TS_W-1:0]       bstart_q;
  logic [SYM_W-1:0]      bsym_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [VOL_W-1:0]      vol_q, bid_q, ask_q;
  logic [TS_W-1:0]       notl_q;
  logic [PRICE_BITS-1:0] fprice_q, lprice_q;

  // output register
  logic                  out_valid_q;
  logic [TS_W-1:0]       o_start_q, o_notl_q;
  logic [SYM_W-1:0]      o_sym_q;
  logic [CNT_W-1:0]      o_cnt_q;
  logic [VOL_W-1:0]      o_vol_q, o_bid_q, o_ask_q;
  logic [PRICE_BITS-1:0] o_vwap_q, o_fprice_q, o_lprice_q;

  // divider and multiplier
  logic               div_start_q, mul_start_q, div_done;
  logic               div_start_d, mul_start_d;
  logic [DIV_N_W-1:0] div_dvd_q, div_quot;
  logic [DIV_D_W-1:0] div_dvs_q, div_rem;
  logic [TS_W-1:0]    prod;

  logic                  accept;
  logic [LEN_W-1:0]      len_eff;
  logic [VOL_W:0]        vol_sum, bid_sum, ask_sum;
  logic [TS_W:0]         notl_sum;
  logic [PRICE_BITS-1:0] vwap_val;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign len_eff    = (len_q == '0) ? LEN_W'(1) : len_q;

  // bucket division on every trade; VWAP division on a flush of an open bar
  // and on a trade that leaves the open interval
  assign mul_start_d = accept && (command_i == CMD_TRADE);
  assign div_start_d = (accept && ((command_i == CMD_TRADE) || open_q)) ||
                       ((state_q == ST_CHECK) && open_q && (start_q != bstart_q));

  assign vol_sum  = {1'b0, vol_q} + (VOL_W + 1)'(size_q);
  assign bid_sum  = {1'b0, bid_q} + (VOL_W + 1)'(size_q);
  assign ask_sum  = {1'b0, ask_q} + (VOL_W + 1)'(size_q);
  assign notl_sum = {1'b0, notl_q} + {1'b0, prod};

  // quotient above the price range only happens after volume saturates
  always_comb begin
    if (vol_q == '0) begin
      vwap_val = '0;
    end else if (|div_quot[TS_W-1:PRICE_BITS]) begin
      vwap_val = '1;
    end else begin
      vwap_val = div_quot[PRICE_BITS-1:0];
    end
  end

  tba_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start_q),
    .dividend_i  (div_dvd_q),
    .divisor_i   (div_dvs_q),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  tba_mul #(
    .PRICE_BITS (PRICE_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .mcand_i (price_q),
    .mplr_i  (size_q),
    .prod_o  (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_TRADE;
      ts_q        <= '0;
      sym_q       <= '0;
      price_q     <= '0;
      size_q      <= '0;
      side_q      <= '0;
      start_q     <= '0;
      open_q      <= 1'b0;
      bstart_q    <= '0;
      bsym_q      <= '0;
      cnt_q       <= '0;
      vol_q       <= '0;
      bid_q       <= '0;
      ask_q       <= '0;
      notl_q      <= '0;
      fprice_q    <= '0;
      lprice_q    <= '0;
      out_valid_q <= 1'b0;
      o_start_q   <= '0;
      o_notl_q    <= '0;
      o_sym_q     <= '0;
      o_cnt_q     <= '0;
      o_vol_q     <= '0;
      o_bid_q     <= '0;
      o_ask_q     <= '0;
      o_vwap_q    <= '0;
      o_fprice_q  <= '0;
      o_lprice_q  <= '0;
      div_start_q <= 1'b0;
      mul_start_q <= 1'b0;
      div_dvd_q   <= '0;
      div_dvs_q   <= '0;
    end else begin
      div_start_q <= div_start_d;
      mul_start_q <= mul_start_d;
      // EMIT reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT)) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= command_i;
            ts_q    <= timestamp_ns_i;
            sym_q   <= symbol_id_i;
            price_q <= price_i;
            size_q  <= size_i;
            side_q  <= side_i;
            if (command_i == CMD_FLUSH) begin
              if (open_q) begin
                div_dvd_q   <= notl_q;
                div_dvs_q   <= vol_q;
                state_q     <= ST_VWAP;
              end
            end else begin
              div_dvd_q   <= timestamp_ns_i;
              div_dvs_q   <= DIV_D_W'(len_eff);
              state_q     <= ST_BUCKET;
            end
          end
        end
        ST_BUCKET: begin
          // multiplier has fewer steps than the divider, so it is done here
          if (div_done) begin
            start_q <= ts_q - TS_W'(div_rem);
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (open_q && (start_q != bstart_q)) begin
            div_dvd_q   <= notl_q;
            div_dvs_q   <= vol_q;
            state_q     <= ST_VWAP;
          end else begin
            state_q <= ST_APPLY;
          end
        end
        ST_VWAP: begin
          if (div_done) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_start_q   <= bstart_q;
            o_sym_q     <= bsym_q;
            o_cnt_q     <= cnt_q;
            o_vol_q     <= vol_q;
            o_notl_q    <= notl_q;
            o_vwap_q    <= vwap_val;
            o_fprice_q  <= fprice_q;
            o_lprice_q  <= lprice_q;
            o_bid_q     <= bid_q;
            o_ask_q     <= ask_q;
            open_q      <= 1'b0;
            bstart_q    <= '0;
            bsym_q      <= '0;
            cnt_q       <= '0;
            vol_q       <= '0;
            notl_q      <= '0;
            fprice_q    <= '0;
            lprice_q    <= '0;
            bid_q       <= '0;
            ask_q       <= '0;
            state_q     <= (cmd_q == CMD_FLUSH) ? ST_IDLE : ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (!open_q) begin
            open_q   <= 1'b1;
            bstart_q <= start_q;
            bsym_q   <= sym_q;
            fprice_q <= price_q;
          end
          if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
          vol_q    <= vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
          notl_q   <= notl_sum[TS_W] ? '1 : notl_sum[TS_W-1:0];
          lprice_q <= price_q;
          if (side_q == SIDE_BID) begin
            bid_q <= bid_sum[VOL_W] ? '1 : bid_sum[VOL_W-1:0];
          end else if (side_q == SIDE_ASK) begin
            ask_q <= ask_sum[VOL_W] ? '1 : ask_sum[VOL_W-1:0];
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bar_start_ns_o  = o_start_q;
  assign bar_symbol_o    = o_sym_q;
  assign trade_count_o   = o_cnt_q;
  assign total_volume_o  = o_vol_q;
  assign dollar_volume_o = o_notl_q;
  assign vwap_o          = o_vwap_q;
  assign first_price_o   = o_fprice_q;
  assign last_price_o    = o_lprice_q;
  assign bid_volume_o    = o_bid_q;
  assign ask_volume_o    = o_ask_q;

endmodule
